// ===== hdl/nd_neighbor_cache_update_defines.svh =====
// ---------------------------------------------------------------------------
// nd_neighbor_cache_update_defines.svh
// Assertion macros shared by the neighbor cache update block.
// ---------------------------------------------------------------------------
`ifndef ND_NEIGHBOR_CACHE_UPDATE_DEFINES_SVH
`define ND_NEIGHBOR_CACHE_UPDATE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define NDCU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define NDCU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ndcu_pkg.sv =====
// ---------------------------------------------------------------------------
// ndcu_pkg
// Types and codes of the neighbor cache update block.
// ---------------------------------------------------------------------------
`default_nettype none

package ndcu_pkg;

    // Message kinds.
    localparam logic [1:0] KIND_NS = 2'd0;
    localparam logic [1:0] KIND_NA = 2'd1;
    localparam logic [1:0] KIND_RA = 2'd2;

    // Reachability states.
    localparam logic [2:0] ST_ABSENT     = 3'd0;
    localparam logic [2:0] ST_INCOMPLETE = 3'd1;
    localparam logic [2:0] ST_REACHABLE  = 3'd2;
    localparam logic [2:0] ST_STALE      = 3'd3;
    localparam logic [2:0] ST_DELAY      = 3'd4;
    localparam logic [2:0] ST_PROBE      = 3'd5;

    // Default router list actions.
    localparam logic [1:0] RL_NONE  = 2'd0;
    localparam logic [1:0] RL_ENTER = 2'd1;
    localparam logic [1:0] RL_LEAVE = 2'd2;

    // Minimum ICMP lengths.
    localparam logic [15:0] MIN_LEN_NSNA = 16'd24;
    localparam logic [15:0] MIN_LEN_RA   = 16'd16;

    // Bit positions in header_flags.
    localparam int HF_TGT_MCAST   = 0;
    localparam int HF_SRC_UNSPEC  = 1;
    localparam int HF_DST_MCAST   = 2;
    localparam int HF_ZERO_OPTLEN = 3;

    // Bit positions in adv_flags.
    localparam int AF_OVERRIDE  = 0;
    localparam int AF_SOLICITED = 1;
    localparam int AF_ROUTER    = 2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  icmp_code;
        logic [15:0] icmp_length;
        logic [3:0]  header_flags;
        logic        lla_present;
        logic [47:0] lla;
        logic [2:0]  adv_flags;
        logic [2:0]  entry_state;
        logic [47:0] cached_lla;
        logic        cached_is_router;
        logic        can_create;
        logic [15:0] ra_lifetime;
    } ndcu_req_t;

    typedef struct packed {
        logic        accepted;
        logic        write_entry;
        logic [2:0]  new_state;
        logic [47:0] new_lla;
        logic        new_is_router;
        logic        stamp_time;
        logic        flush_queue;
        logic [1:0]  router_list_action;
        logic        write_lifetime;
        logic [15:0] new_lifetime;
    } ndcu_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/ndcu_if.sv =====
// ---------------------------------------------------------------------------
// ndcu_if
// Valid/ready channels for messages and verdicts of the cache update block.
// ---------------------------------------------------------------------------
`default_nettype none

// Message channel.
interface ndcu_req_if;
    logic                  valid;
    logic                  ready;
    ndcu_pkg::ndcu_req_t   data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Verdict channel.
interface ndcu_rsp_if;
    logic                  valid;
    logic                  ready;
    ndcu_pkg::ndcu_rsp_t   data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/ndcu_decide.sv =====
// ---------------------------------------------------------------------------
// ndcu_decide
// Validation and entry update decision for one neighbor discovery message.
// ---------------------------------------------------------------------------
`default_nettype none

module ndcu_decide (
    input  wire ndcu_pkg::ndcu_req_t req,
    output ndcu_pkg::ndcu_rsp_t      rsp
);
    import ndcu_pkg::*;

    logic [2:0] st;
    logic       addr_diff;
    logic       sol;
    logic       ovr;
    logic       rtr;

    // Out-of-range entry states count as absent.
    assign st        = (req.entry_state > ST_PROBE) ? ST_ABSENT : req.entry_state;
    assign addr_diff = (req.cached_lla != req.lla);
    assign sol       = req.adv_flags[AF_SOLICITED];
    assign ovr       = req.adv_flags[AF_OVERRIDE];
    assign rtr       = req.adv_flags[AF_ROUTER];

    always_comb
    begin
        logic have;
        have = 1'b0;
        rsp  = '0;

        if (req.icmp_code == 8'd0)
        begin
            unique case (req.kind)
                // Neighbor solicitation.
                KIND_NS:
                begin
                    if (req.icmp_length >= MIN_LEN_NSNA && !req.header_flags[HF_TGT_MCAST]
                        && !req.header_flags[HF_ZERO_OPTLEN])
                    begin
                        if (!req.lla_present)
                        begin
                            rsp.accepted = 1'b1;
                        end
                        else if (!req.header_flags[HF_SRC_UNSPEC])
                        begin
                            rsp.accepted = 1'b1;
                            if (st == ST_ABSENT)
                            begin
                                if (req.can_create)
                                begin
                                    rsp.write_entry = 1'b1;
                                    rsp.new_state   = ST_STALE;
                                    rsp.new_lla     = req.lla;
                                    rsp.stamp_time  = 1'b1;
                                end
                            end
                            else if (st == ST_INCOMPLETE || addr_diff)
                            begin
                                rsp.write_entry   = 1'b1;
                                rsp.new_state     = ST_STALE;
                                rsp.new_lla       = req.lla;
                                rsp.new_is_router = req.cached_is_router;
                                rsp.stamp_time    = 1'b1;
                                rsp.flush_queue   = (st == ST_INCOMPLETE);
                            end
                        end
                    end
                end

                // Neighbor advertisement.
                KIND_NA:
                begin
                    if (req.icmp_length >= MIN_LEN_NSNA && !req.header_flags[HF_TGT_MCAST]
                        && !req.header_flags[HF_ZERO_OPTLEN]
                        && !(req.header_flags[HF_DST_MCAST] && sol) && req.lla_present)
                    begin
                        rsp.accepted = 1'b1;
                        if (st != ST_ABSENT)
                        begin
                            if (st == ST_INCOMPLETE)
                            begin
                                rsp.write_entry   = 1'b1;
                                rsp.new_lla       = req.lla;
                                rsp.new_state     = sol ? ST_REACHABLE : ST_STALE;
                                rsp.new_is_router = rtr;
                                rsp.stamp_time    = 1'b1;
                                rsp.flush_queue   = 1'b1;
                            end
                            else if (!ovr && addr_diff)
                            begin
                                // A differing address without override only ages a
                                // reachable entry.
                                if (st == ST_REACHABLE)
                                begin
                                    rsp.write_entry   = 1'b1;
                                    rsp.new_state     = ST_STALE;
                                    rsp.new_lla       = req.cached_lla;
                                    rsp.new_is_router = req.cached_is_router;
                                    rsp.stamp_time    = 1'b1;
                                end
                            end
                            else
                            begin
                                rsp.write_entry   = 1'b1;
                                rsp.new_lla       = req.lla;
                                rsp.new_is_router = rtr;
                                if (sol)
                                begin
                                    rsp.new_state = ST_REACHABLE;
                                end
                                else if (addr_diff)
                                begin
                                    rsp.new_state = ST_STALE;
                                end
                                else
                                begin
                                    rsp.new_state = st;
                                end
                                rsp.stamp_time = (rsp.new_state != st)
                                    || (rsp.new_state == ST_REACHABLE);
                            end
                            if (rsp.write_entry && req.cached_is_router && !rsp.new_is_router)
                            begin
                                rsp.router_list_action = RL_LEAVE;
                            end
                        end
                    end
                end

                // Router advertisement.
                KIND_RA:
                begin
                    if (req.icmp_length >= MIN_LEN_RA && !req.header_flags[HF_ZERO_OPTLEN])
                    begin
                        rsp.accepted = 1'b1;
                        // An absent entry that cannot be created ends processing.
                        if (!(req.lla_present && st == ST_ABSENT && !req.can_create))
                        begin
                            if (req.lla_present)
                            begin
                                have              = 1'b1;
                                rsp.write_entry   = 1'b1;
                                rsp.new_lla       = req.lla;
                                rsp.new_is_router = 1'b1;
                                rsp.stamp_time    = 1'b1;
                                if (st == ST_ABSENT || st == ST_INCOMPLETE)
                                begin
                                    rsp.new_state = ST_STALE;
                                end
                                else if (st == ST_STALE || !addr_diff)
                                begin
                                    rsp.new_state = st;
                                end
                                else
                                begin
                                    rsp.new_state = ST_STALE;
                                end
                                rsp.flush_queue = (st == ST_INCOMPLETE);
                            end
                            else if (st != ST_ABSENT)
                            begin
                                have              = 1'b1;
                                rsp.write_entry   = 1'b1;
                                rsp.new_state     = st;
                                rsp.new_lla       = req.cached_lla;
                                rsp.new_is_router = 1'b1;
                            end

                            if (req.ra_lifetime == 16'd0)
                            begin
                                if (have)
                                begin
                                    rsp.router_list_action = RL_LEAVE;
                                    rsp.write_lifetime     = 1'b1;
                                end
                            end
                            else if (have || req.can_create)
                            begin
                                // Without an entry, a bare router entry is created.
                                if (!have)
                                begin
                                    rsp.write_entry   = 1'b1;
                                    rsp.new_state     = ST_ABSENT;
                                    rsp.new_lla       = '0;
                                    rsp.new_is_router = 1'b1;
                                end
                                rsp.write_lifetime     = 1'b1;
                                rsp.new_lifetime       = req.ra_lifetime;
                                rsp.router_list_action = RL_ENTER;
                            end
                        end
                    end
                end

                // Unknown kind is dropped.
                default:
                begin
                    rsp = '0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/nd_neighbor_cache_update.sv =====
// The block takes one message per cycle, save for the stall below, and returns one
// verdict for each: the message is captured in an input register, the validation and
// update decision is evaluated in one pass of logic, and the verdict sits in a result
// register until it is taken. While a finished verdict waits, one more message can
// still be taken into an empty input register; the input stalls only when both
// registers are full and the verdict side is not ready. Throughput is one beat per
// cycle whenever the verdict side is ready. There is no internal state beyond these
// two stages.
// ---------------------------------------------------------------------------
// nd_neighbor_cache_update
// Neighbor discovery cache update: two-stage pipeline around the decision logic.
// ---------------------------------------------------------------------------
`default_nettype none

`include "nd_neighbor_cache_update_defines.svh"

module nd_neighbor_cache_update (
    input  wire         clk,
    input  wire         rst_n,
    ndcu_req_if.sink    req,
    ndcu_rsp_if.source  rsp
);
    import ndcu_pkg::*;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    ndcu_req_t  s1_data_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    ndcu_rsp_t  out_data_reg;
    ndcu_rsp_t  decision;
    logic       out_load;
    logic       in_fire;

    // Handshake control.
    assign out_load  = !out_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || out_load;
    assign in_fire   = req.valid && req.ready;

    assign s1_valid_next  = in_fire ? 1'b1 : (out_load ? 1'b0 : s1_valid_reg);
    assign out_valid_next = out_load ? s1_valid_reg : out_valid_reg;

    // Decision logic between the two registers.
    ndcu_decide u_decide (
        .req (s1_data_reg),
        .rsp (decision)
    );

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_data_reg <= req.data;
        end
        if (out_load && s1_valid_reg)
        begin
            out_data_reg <= decision;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // Checks on the pipeline and on the verdict encoding.
    `NDCU_ASSERT_NEXT(a_s1_held, s1_valid_reg && out_valid_reg && !rsp.ready, s1_valid_reg, "input stage lost a beat while the result was stalled")
    `NDCU_ASSERT_SAME(a_drop_clean, rsp.valid && !rsp.data.accepted, !rsp.data.write_entry && !rsp.data.write_lifetime && rsp.data.router_list_action == RL_NONE, "dropped message carries writes")
    `NDCU_ASSERT_SAME(a_lifetime_zero, rsp.valid && !rsp.data.write_lifetime, rsp.data.new_lifetime == 16'd0, "lifetime value without lifetime write")
    `NDCU_ASSERT_SAME(a_flush_write, rsp.valid && rsp.data.flush_queue, rsp.data.write_entry && rsp.data.stamp_time, "queue flush without entry write")

endmodule

`default_nettype wire
